/* rtl/ehp_pkg.sv */
// Shared types, constants and codes for the Ethernet encapsulation header parser.
package ehp_pkg;

    localparam int MAX_MPLS_ENTRIES = 8;
    localparam int MAX_VLAN_TAGS    = 4;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [15:0] ETYPE_CTAG   = 16'h8100;
    localparam logic [15:0] ETYPE_STAG   = 16'h88A8;
    localparam logic [15:0] ETYPE_MPLS_U = 16'h8847;
    localparam logic [15:0] ETYPE_MPLS_M = 16'h8848;

    localparam logic [15:0] ETH_TYPE_POS = 16'd13;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [3:0]  NIB_IPV4     = 4'd4;
    localparam logic [3:0]  NIB_IPV6     = 4'd6;

    localparam logic [1:0] KIND_ETH  = 2'd0;
    localparam logic [1:0] KIND_VLAN = 2'd1;
    localparam logic [1:0] KIND_MPLS = 2'd2;
    localparam logic [1:0] KIND_SUM  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_VLAN_TRUNC = 3'd2;
    localparam logic [2:0] ST_MPLS_TRUNC = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_TOO_MANY   = 3'd5;
    localparam logic [2:0] ST_NO_INNER   = 3'd6;

    localparam logic [0:0] REG_BASE_OFFSET = 1'b0;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_VLAN,
        PH_MPLS,
        PH_NIBBLE,
        PH_DONE
    } t_phase;

    // One queued entry: the record a byte closes, the summary, or both.
    typedef struct packed {
        logic        has_rec;
        logic [1:0]  rec_kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] type_value;
        logic [19:0] tag_id;
        logic [2:0]  priority_res;
        logic [7:0]  hop_limit;
        logic        bottom_of_stack;
        logic [2:0]  entry_index;
        logic [15:0] rec_pos;
        logic        has_sum;
        logic [15:0] sum_type;
        logic [15:0] sum_pos;
        logic [2:0]  sum_status;
    } t_job;

endpackage

/* rtl/ehp_front.sv */
// Front end: takes frame bytes, runs the header parse and queues record jobs.
module ehp_front
    import ehp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_first_of_frame,
    input  logic       i_last_of_frame,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [2:0] VLAN_MAX_C = 3'(MAX_VLAN_TAGS);
    localparam logic [3:0] MPLS_MAX_C = 4'(MAX_MPLS_ENTRIES);

    logic [15:0] r_byte_count, n_byte_count;
    t_phase      r_phase, n_phase;
    logic [47:0] r_dst, n_dst;
    logic [47:0] r_src, n_src;
    logic [31:0] r_word, n_word;
    logic [1:0]  r_phase_bytes, n_phase_bytes;
    logic [2:0]  r_vlan_count, n_vlan_count;
    logic [3:0]  r_mpls_count, n_mpls_count;
    logic [15:0] r_routed_type, n_routed_type;
    logic [15:0] r_payload, n_payload;
    logic [2:0]  r_status, n_status;

    logic        accept;
    t_job        job;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (job.has_rec || job.has_sum);
    assign o_job   = job;

    always_comb begin
        logic [15:0] pos;
        logic [15:0] pos_next;
        logic        do_route;
        logic [15:0] route_type;

        n_byte_count  = r_byte_count;
        n_phase       = r_phase;
        n_dst         = r_dst;
        n_src         = r_src;
        n_word        = r_word;
        n_phase_bytes = r_phase_bytes;
        n_vlan_count  = r_vlan_count;
        n_mpls_count  = r_mpls_count;
        n_routed_type = r_routed_type;
        n_payload     = r_payload;
        n_status      = r_status;
        job           = '0;
        do_route      = 1'b0;
        route_type    = '0;

        if (i_first_of_frame) begin
            n_byte_count  = '0;
            n_phase       = PH_ETH;
            n_dst         = '0;
            n_src         = '0;
            n_word        = '0;
            n_phase_bytes = '0;
            n_vlan_count  = '0;
            n_mpls_count  = '0;
            n_routed_type = '0;
            n_payload     = '0;
            n_status      = ST_OK;
        end

        pos      = n_byte_count;
        pos_next = (pos == POS_MAX) ? pos : pos + 16'd1;

        unique case (n_phase)
            PH_ETH: begin
                if (pos < 16'd6) begin
                    n_dst = {n_dst[39:0], i_frame_byte};
                end else if (pos < 16'd12) begin
                    n_src = {n_src[39:0], i_frame_byte};
                end else begin
                    n_word = {16'h0, n_word[7:0], i_frame_byte};
                end
                if (pos == ETH_TYPE_POS) begin
                    job.has_rec    = 1'b1;
                    job.rec_kind   = KIND_ETH;
                    job.dst_mac    = n_dst;
                    job.src_mac    = n_src;
                    job.type_value = n_word[15:0];
                    job.rec_pos    = '0;
                    do_route       = 1'b1;
                    route_type     = n_word[15:0];
                end
            end
            PH_VLAN: begin
                n_word        = {n_word[23:0], i_frame_byte};
                n_phase_bytes = n_phase_bytes + 2'd1;
                if (n_phase_bytes == 2'd0) begin
                    job.has_rec      = 1'b1;
                    job.rec_kind     = KIND_VLAN;
                    job.type_value   = n_word[15:0];
                    job.tag_id       = {8'h0, n_word[27:16]};
                    job.priority_res = n_word[31:29];
                    job.entry_index  = n_vlan_count;
                    job.rec_pos      = n_payload;
                    n_vlan_count     = n_vlan_count + 3'd1;
                    do_route         = 1'b1;
                    route_type       = n_word[15:0];
                end
            end
            PH_MPLS: begin
                n_word        = {n_word[23:0], i_frame_byte};
                n_phase_bytes = n_phase_bytes + 2'd1;
                if (n_phase_bytes == 2'd0) begin
                    job.has_rec         = 1'b1;
                    job.rec_kind        = KIND_MPLS;
                    job.tag_id          = n_word[31:12];
                    job.priority_res    = n_word[11:9];
                    job.hop_limit       = n_word[7:0];
                    job.bottom_of_stack = n_word[8];
                    job.entry_index     = n_mpls_count[2:0];
                    job.rec_pos         = n_payload;
                    n_mpls_count        = n_mpls_count + 4'd1;
                    n_payload           = pos_next;
                    if (n_word[8] || n_mpls_count >= MPLS_MAX_C) begin
                        n_phase = PH_NIBBLE;
                    end
                    n_word = '0;
                end
            end
            PH_NIBBLE: begin
                if (i_frame_byte[7:4] == NIB_IPV4) begin
                    n_routed_type = ETYPE_IPV4;
                    n_status      = ST_OK;
                end else if (i_frame_byte[7:4] == NIB_IPV6) begin
                    n_routed_type = ETYPE_IPV6;
                    n_status      = ST_OK;
                end else begin
                    n_routed_type = '0;
                    n_status      = ST_NO_INNER;
                end
                n_phase = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (do_route) begin
            n_payload     = pos_next;
            n_phase_bytes = '0;
            n_word        = '0;
            unique case (route_type)
                ETYPE_IPV4, ETYPE_IPV6, ETYPE_ARP: begin
                    n_routed_type = route_type;
                    n_status      = ST_OK;
                    n_phase       = PH_DONE;
                end
                ETYPE_CTAG, ETYPE_STAG: begin
                    if (n_vlan_count >= VLAN_MAX_C) begin
                        n_status = ST_TOO_MANY;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_VLAN;
                    end
                end
                ETYPE_MPLS_U, ETYPE_MPLS_M: begin
                    n_mpls_count = '0;
                    n_phase      = PH_MPLS;
                end
                default: begin
                    n_status = ST_UNKNOWN;
                    n_phase  = PH_DONE;
                end
            endcase
        end

        n_byte_count = pos_next;

        if (i_last_of_frame) begin
            job.has_sum  = 1'b1;
            job.sum_pos  = n_payload;
            job.sum_type = '0;
            unique case (n_phase)
                PH_ETH: begin
                    job.sum_status = ST_SHORT;
                    job.sum_pos    = '0;
                end
                PH_VLAN: job.sum_status = ST_VLAN_TRUNC;
                PH_MPLS: begin
                    job.sum_status = (n_phase_bytes != 2'd0 || n_mpls_count == 4'd0)
                                   ? ST_MPLS_TRUNC : ST_NO_INNER;
                end
                PH_NIBBLE: job.sum_status = ST_NO_INNER;
                default: begin
                    job.sum_status = n_status;
                    job.sum_type   = (n_status == ST_OK) ? n_routed_type : '0;
                end
            endcase
            n_byte_count  = '0;
            n_phase       = PH_ETH;
            n_dst         = '0;
            n_src         = '0;
            n_word        = '0;
            n_phase_bytes = '0;
            n_vlan_count  = '0;
            n_mpls_count  = '0;
            n_routed_type = '0;
            n_payload     = '0;
            n_status      = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_phase       <= PH_ETH;
            r_dst         <= '0;
            r_src         <= '0;
            r_word        <= '0;
            r_phase_bytes <= '0;
            r_vlan_count  <= '0;
            r_mpls_count  <= '0;
            r_routed_type <= '0;
            r_payload     <= '0;
            r_status      <= ST_OK;
        end else if (accept) begin
            r_byte_count  <= n_byte_count;
            r_phase       <= n_phase;
            r_dst         <= n_dst;
            r_src         <= n_src;
            r_word        <= n_word;
            r_phase_bytes <= n_phase_bytes;
            r_vlan_count  <= n_vlan_count;
            r_mpls_count  <= n_mpls_count;
            r_routed_type <= n_routed_type;
            r_payload     <= n_payload;
            r_status      <= n_status;
        end
    end

endmodule

/* rtl/ehp_queue.sv */
// Short job queue between the parse front end and the record emitter.
module ehp_queue
    import ehp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [JOB_PTR_W:0]   r_count;

    assign o_full  = (r_count == (JOB_PTR_W + 1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full job queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty job queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (JOB_PTR_W + 1)'(JOB_DEPTH))
        else $error("job queue count out of range");

endmodule

/* rtl/ehp_back.sv */
// Back end: expands queued jobs into records held in the output register.
module ehp_back
    import ehp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_base_offset,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_record_kind,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_type_value,
    output logic [19:0] o_tag_id,
    output logic [2:0]  o_priority_res,
    output logic [7:0]  o_hop_limit,
    output logic        o_bottom_of_stack,
    output logic [2:0]  o_entry_index,
    output logic [15:0] o_field_offset,
    output logic [2:0]  o_status,
    output logic        o_last_of_run
);

    logic        r_valid, n_valid;
    logic        r_half, n_half;
    logic [1:0]  r_kind;
    logic [47:0] r_dst, r_src;
    logic [15:0] r_type;
    logic [19:0] r_id;
    logic [2:0]  r_pri;
    logic [7:0]  r_hop;
    logic        r_bos;
    logic [2:0]  r_idx;
    logic [15:0] r_off;
    logic [2:0]  r_stat;
    logic        r_last;

    logic        load;
    logic        both;
    logic        take_sum;

    assign load     = !r_valid || i_ready;
    assign both     = i_job.has_rec && i_job.has_sum;
    // r_half: the record half of a two-record job went out, summary is next
    assign take_sum = r_half || !i_job.has_rec;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_half = both && !r_half;
                o_pop  = !(both && !r_half);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (take_sum) begin
                r_kind <= KIND_SUM;
                r_dst  <= '0;
                r_src  <= '0;
                r_type <= i_job.sum_type;
                r_id   <= '0;
                r_pri  <= '0;
                r_hop  <= '0;
                r_bos  <= 1'b0;
                r_idx  <= '0;
                r_off  <= i_base_offset + i_job.sum_pos;
                r_stat <= i_job.sum_status;
                r_last <= 1'b1;
            end else begin
                r_kind <= i_job.rec_kind;
                r_dst  <= i_job.dst_mac;
                r_src  <= i_job.src_mac;
                r_type <= i_job.type_value;
                r_id   <= i_job.tag_id;
                r_pri  <= i_job.priority_res;
                r_hop  <= i_job.hop_limit;
                r_bos  <= i_job.bottom_of_stack;
                r_idx  <= i_job.entry_index;
                r_off  <= i_base_offset + i_job.rec_pos;
                r_stat <= ST_OK;
                r_last <= !i_job.has_sum;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_record_kind     = r_kind;
    assign o_dst_mac         = r_dst;
    assign o_src_mac         = r_src;
    assign o_type_value      = r_type;
    assign o_tag_id          = r_id;
    assign o_priority_res    = r_pri;
    assign o_hop_limit       = r_hop;
    assign o_bottom_of_stack = r_bos;
    assign o_entry_index     = r_idx;
    assign o_field_offset    = r_off;
    assign o_status          = r_stat;
    assign o_last_of_run     = r_last;

    a_half_holds_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> !i_empty)
        else $error("summary half pending with no job in queue");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_SUM) |-> r_last)
        else $error("summary record not marked last of run");

    a_pop_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (load && !i_empty))
        else $error("job popped while output register busy");

endmodule

/* rtl/ethernet_encap_header_parser.sv */
// Top level: Ethernet / VLAN / MPLS header parser with base offset register.
//
//   channel   direction  handshake            payload
//   byte in   input      i_valid / o_ready    i_frame_byte, first/last marks
//   record    output     o_valid / i_ready    o_record_kind .. o_last_of_run
//   config    input      psel/penable/pready  paddr, pwdata, prdata
//
// One byte is taken per cycle while the 4-entry job queue has room.
// A byte that closes a header and also ends the frame yields two records,
// which take the output register one after the other; the queue absorbs that.
// A record passes through the job queue and then the output register before it is offered.
// Reset is synchronous; no clearing pass follows it.
module ethernet_encap_header_parser
    import ehp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_first_of_frame,
    input  logic        i_last_of_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_record_kind,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_type_value,
    output logic [19:0] o_tag_id,
    output logic [2:0]  o_priority_res,
    output logic [7:0]  o_hop_limit,
    output logic        o_bottom_of_stack,
    output logic [2:0]  o_entry_index,
    output logic [15:0] o_field_offset,
    output logic [2:0]  o_status,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_base_offset;
    logic        push, pop, full, empty;
    t_job        job_in, job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE_OFFSET) ? {16'h0, r_base_offset} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BASE_OFFSET) begin
            r_base_offset <= pwdata[15:0];
        end
    end

    ehp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_byte     (i_frame_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .i_full           (full),
        .o_push           (push),
        .o_job            (job_in)
    );

    ehp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    ehp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_base_offset     (r_base_offset),
        .i_job             (job_out),
        .i_empty           (empty),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_record_kind     (o_record_kind),
        .o_dst_mac         (o_dst_mac),
        .o_src_mac         (o_src_mac),
        .o_type_value      (o_type_value),
        .o_tag_id          (o_tag_id),
        .o_priority_res    (o_priority_res),
        .o_hop_limit       (o_hop_limit),
        .o_bottom_of_stack (o_bottom_of_stack),
        .o_entry_index     (o_entry_index),
        .o_field_offset    (o_field_offset),
        .o_status          (o_status),
        .o_last_of_run     (o_last_of_run)
    );

endmodule
